FILE: hdl/tcc_pkg.sv
// Shared types, codes and the threshold table of the charge-temperature zone block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package tcc_pkg;

  // Output zone codes.
  localparam logic [2:0] ZONE_LOW_ERR   = 3'd0;
  localparam logic [2:0] ZONE_LOW_WARN  = 3'd1;
  localparam logic [2:0] ZONE_HIGH_WARN = 3'd2;
  localparam logic [2:0] ZONE_HIGH_ERR  = 3'd3;
  localparam logic [2:0] ZONE_NORMAL    = 3'd4;

  // Source row codes.
  localparam logic [1:0] SRC_WIRED    = 2'd0;
  localparam logic [1:0] SRC_WIRELESS = 2'd1;
  localparam logic [1:0] SRC_BATT     = 2'd2;

  // Error LED event codes.
  localparam logic [1:0] LED_NONE = 2'd0;
  localparam logic [1:0] LED_ON   = 2'd1;
  localparam logic [1:0] LED_OFF  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_CODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_CODE = 4'd1;

  localparam logic [3:0] RST_WARN_CODE   = 4'd7;
  localparam logic [3:0] RST_NORMAL_CODE = 4'd11;
  localparam logic [3:0] ERR_CURRENT     = 4'd0;

  // Threshold columns within one source row.
  localparam logic [2:0] COL_LE_IN  = 3'd0;
  localparam logic [2:0] COL_LE_OUT = 3'd1;
  localparam logic [2:0] COL_LW_IN  = 3'd2;
  localparam logic [2:0] COL_LW_OUT = 3'd3;
  localparam logic [2:0] COL_HW_IN  = 3'd4;
  localparam logic [2:0] COL_HW_OUT = 3'd5;
  localparam logic [2:0] COL_HE_IN  = 3'd6;
  localparam logic [2:0] COL_HE_OUT = 3'd7;

  // Integer thresholds in degrees C, one row per source.
  localparam logic [7:0] THR_WIRED [8] = '{8'd0, 8'd2, 8'd5, 8'd7, 8'd40, 8'd38, 8'd45, 8'd43};
  localparam logic [7:0] THR_WLESS [8] = '{8'd0, 8'd2, 8'd5, 8'd7, 8'd43, 8'd41, 8'd45, 8'd43};
  localparam logic [7:0] THR_BATT  [8] = '{8'd0, 8'd2, 8'd5, 8'd7, 8'd43, 8'd41, 8'd50, 8'd48};

  // One-hot zone state of the hysteresis machine.
  typedef enum logic [4:0] {
    ZS_LOW_ERR   = 5'b00001,
    ZS_LOW_WARN  = 5'b00010,
    ZS_HIGH_WARN = 5'b00100,
    ZS_HIGH_ERR  = 5'b01000,
    ZS_NORMAL    = 5'b10000
  } zone_state_t;

  // Current codes held in the configuration registers.
  typedef struct packed {
    logic [3:0] warn_code;
    logic [3:0] normal_code;
  } cfg_regs_t;

  // One result item.
  typedef struct packed {
    logic [2:0] zone;
    logic [1:0] source;
    logic       charging_enabled;
    logic [3:0] current_code;
    logic       current_changed;
    logic [1:0] error_led_event;
  } result_t;

  // Threshold lookup for one source row and column.
  function automatic logic [7:0] thr_deg(logic [1:0] src, logic [2:0] col);
    logic [7:0] val;
    case (src)
      SRC_WIRED:    val = THR_WIRED[col];
      SRC_WIRELESS: val = THR_WLESS[col];
      default:      val = THR_BATT[col];
    endcase
    return val;
  endfunction

  // Output code of a zone state.
  function automatic logic [2:0] zone_code(zone_state_t zs);
    logic [2:0] code;
    case (zs)
      ZS_LOW_ERR:   code = ZONE_LOW_ERR;
      ZS_LOW_WARN:  code = ZONE_LOW_WARN;
      ZS_HIGH_WARN: code = ZONE_HIGH_WARN;
      ZS_HIGH_ERR:  code = ZONE_HIGH_ERR;
      default:      code = ZONE_NORMAL;
    endcase
    return code;
  endfunction

  function automatic logic zone_is_err(zone_state_t zs);
    return (zs == ZS_LOW_ERR) || (zs == ZS_HIGH_ERR);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tcc_cfg_regs.sv
// Configuration register file holding the warning and normal current codes.
// Depends on tcc_pkg for register indexes, reset values and cfg_regs_t.
`default_nettype none

module tcc_cfg_regs
  import tcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [3:0]           cfg_data,
  output cfg_regs_t                 regs
);

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.warn_code   <= RST_WARN_CODE;
      regs.normal_code <= RST_NORMAL_CODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WARN_CODE:   regs.warn_code   <= cfg_data;
        REG_NORMAL_CODE: regs.normal_code <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tcc_zone_logic.sv
// Next-zone, current reload and LED event logic for one temperature sample.
// Depends on tcc_pkg for zone states, threshold table and the result struct.
`default_nettype none

module tcc_zone_logic
  import tcc_pkg::*;
#(
  parameter int TEMP_FRAC_BITS = 8
) (
  input  wire logic signed [15:0] temp_q8,
  input  wire logic               wired_present,
  input  wire logic               wireless_present,
  input  zone_state_t             zone_state,
  input  wire logic [3:0]         current_reg,
  input  cfg_regs_t               regs,
  output zone_state_t             zone_state_next,
  output logic [3:0]              current_next,
  output result_t                 result
);

  logic [1:0]         src;
  logic               attached;
  logic signed [31:0] t_ext;
  logic [2:0]         col_a;
  logic [2:0]         col_b;
  logic signed [31:0] thr_a;
  logic signed [31:0] thr_b;
  logic               gt_a;
  logic               lt_a;
  logic               gt_b;
  logic               lt_b;
  logic [1:0]         led;

  // Source priority: wired, then wireless, then battery only.
  always_comb begin
    if (wired_present) begin
      src = SRC_WIRED;
    end else if (wireless_present) begin
      src = SRC_WIRELESS;
    end else begin
      src = SRC_BATT;
    end
  end

  assign attached = (src != SRC_BATT);
  assign t_ext    = {{16{temp_q8[15]}}, temp_q8};

  // Each zone checks at most two thresholds; pick their columns first.
  always_comb begin
    case (zone_state)
      ZS_LOW_ERR: begin
        col_a = COL_LE_OUT;
        col_b = COL_LE_OUT;
      end
      ZS_LOW_WARN: begin
        col_a = COL_LE_IN;
        col_b = COL_LW_OUT;
      end
      ZS_HIGH_WARN: begin
        col_a = COL_HW_OUT;
        col_b = COL_HE_IN;
      end
      ZS_HIGH_ERR: begin
        col_a = COL_HE_OUT;
        col_b = COL_HE_OUT;
      end
      default: begin
        col_a = COL_HW_IN;
        col_b = COL_LW_IN;
      end
    endcase
  end

  // Thresholds scaled to the sample's fixed-point format.
  assign thr_a = $signed({24'd0, thr_deg(src, col_a)}) <<< TEMP_FRAC_BITS;
  assign thr_b = $signed({24'd0, thr_deg(src, col_b)}) <<< TEMP_FRAC_BITS;
  assign gt_a  = (t_ext > thr_a);
  assign lt_a  = (t_ext < thr_a);
  assign gt_b  = (t_ext > thr_b);
  assign lt_b  = (t_ext < thr_b);

  // Hysteresis transitions with strict compares.
  always_comb begin
    case (zone_state)
      ZS_LOW_ERR: begin
        zone_state_next = gt_a ? ZS_LOW_WARN : ZS_LOW_ERR;
      end
      ZS_LOW_WARN: begin
        if (lt_a) begin
          zone_state_next = ZS_LOW_ERR;
        end else if (gt_b) begin
          zone_state_next = ZS_NORMAL;
        end else begin
          zone_state_next = ZS_LOW_WARN;
        end
      end
      ZS_HIGH_WARN: begin
        if (lt_a) begin
          zone_state_next = ZS_NORMAL;
        end else if (gt_b) begin
          zone_state_next = ZS_HIGH_ERR;
        end else begin
          zone_state_next = ZS_HIGH_WARN;
        end
      end
      ZS_HIGH_ERR: begin
        zone_state_next = lt_a ? ZS_HIGH_WARN : ZS_HIGH_ERR;
      end
      ZS_NORMAL: begin
        if (gt_a) begin
          zone_state_next = ZS_HIGH_WARN;
        end else if (lt_b) begin
          zone_state_next = ZS_LOW_WARN;
        end else begin
          zone_state_next = ZS_NORMAL;
        end
      end
      default: begin
        zone_state_next = ZS_NORMAL;
      end
    endcase
  end

  // The held current is reloaded only while a charger is attached.
  always_comb begin
    if (!attached) begin
      current_next = current_reg;
    end else if (zone_is_err(zone_state_next)) begin
      current_next = ERR_CURRENT;
    end else if (zone_state_next == ZS_NORMAL) begin
      current_next = regs.normal_code;
    end else begin
      current_next = regs.warn_code;
    end
  end

  // LED events fire only on zone changes into or out of an error zone.
  always_comb begin
    led = LED_NONE;
    if (zone_state_next != zone_state) begin
      if (zone_is_err(zone_state_next)) begin
        led = LED_ON;
      end else if (zone_is_err(zone_state)) begin
        led = LED_OFF;
      end
    end
  end

  assign result.zone             = zone_code(zone_state_next);
  assign result.source           = src;
  assign result.charging_enabled = attached && !zone_is_err(zone_state_next);
  assign result.current_code     = current_next;
  assign result.current_changed  = (current_next != current_reg);
  assign result.error_led_event  = led;

endmodule

`default_nettype wire

FILE: hdl/thermal_charge_current_fsm.sv
// Top level of the charge-temperature zone controller: input and result registers,
// zone and current state. Depends on tcc_pkg, tcc_cfg_regs and tcc_zone_logic.
//
// The block takes one temperature sample with two charger attach flags per
// request and returns one result per request: the new zone, the selected
// threshold row, whether charging is enabled, the held current code, a
// current-changed flag and an error LED event. It accepts one request every
// clock cycle while in_stall is low. A request waits in the input register
// until the result register is free; the zone compare logic then runs from the
// input register into the result register, and the zone and current state are
// updated at the edge that loads the result register. The result register
// frees while its result is taken, so a stall on the result side holds only
// once both registers are full. Configuration writes are always ready and
// should be made while no request is in flight.
`default_nettype none

module thermal_charge_current_fsm
  import tcc_pkg::*;
#(
  parameter int TEMP_FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Sample channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [15:0]   temp_q8,
  input  wire logic                 wired_present,
  input  wire logic                 wireless_present,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                zone,
  output logic [1:0]                source,
  output logic                      charging_enabled,
  output logic [3:0]                current_code,
  output logic                      current_changed,
  output logic [1:0]                error_led_event,
  // Configuration channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [3:0]           cfg_data
);

  cfg_regs_t          regs;
  logic               s1_valid;
  logic signed [15:0] s1_temp;
  logic               s1_wired;
  logic               s1_wireless;
  zone_state_t        zone_state;
  zone_state_t        zone_state_next;
  logic [3:0]         current_reg;
  logic [3:0]         current_next;
  result_t            result;
  logic               out_free;
  logic               advance;
  logic               in_accept;

  tcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  tcc_zone_logic #(
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
  ) u_zone (
    .temp_q8          (s1_temp),
    .wired_present    (s1_wired),
    .wireless_present (s1_wireless),
    .zone_state       (zone_state),
    .current_reg      (current_reg),
    .regs             (regs),
    .zone_state_next  (zone_state_next),
    .current_next     (current_next),
    .result           (result)
  );

  // Handshake: the result register is free when empty or being taken.
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_temp     <= temp_q8;
      s1_wired    <= wired_present;
      s1_wireless <= wireless_present;
    end
  end

  // Zone and current state move together with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_state  <= ZS_NORMAL;
      current_reg <= 4'd0;
    end else if (advance) begin
      zone_state  <= zone_state_next;
      current_reg <= current_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      zone             <= result.zone;
      source           <= result.source;
      charging_enabled <= result.charging_enabled;
      current_code     <= result.current_code;
      current_changed  <= result.current_changed;
      error_led_event  <= result.error_led_event;
    end
  end

  // The shown result always reflects the state it produced.
  a_zone_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (zone == zone_code(zone_state)))
    else $error("result zone differs from held zone state");

  a_current_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (current_code == current_reg))
    else $error("result current differs from held current");

  // The input register only stalls when it is full.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // A turn-on event names an error zone and disables charging.
  a_led_on_in_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (error_led_event == LED_ON)) |->
      (((zone == ZONE_LOW_ERR) || (zone == ZONE_HIGH_ERR)) && !charging_enabled))
    else $error("error LED turned on outside an error zone");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the charge-temperature zone controller.
// It uses tcc_pkg and thermal_charge_current_fsm directly, and checks every
// result against an in-bench zone and current predictor.
`timescale 1ns / 1ps

module testbench
  import tcc_pkg::*;
();

  localparam int FRAC_BITS = 8;
  localparam int DEG = 1 << FRAC_BITS;
  localparam int PHASES = 6;
  localparam int PHASE_SAMPLES = 255;
  localparam logic [3:0] CODE_MAX = 4'hF;
  localparam logic [3:0] WARN_CODE_RESET = 4'd7;
  localparam logic [3:0] NORMAL_CODE_RESET = 4'd11;
  localparam logic [3:0] NO_CURRENT = 4'd0;

  // Threshold columns within one source row.
  localparam int LIM_LE_IN = 0;
  localparam int LIM_LE_OUT = 1;
  localparam int LIM_LW_IN = 2;
  localparam int LIM_LW_OUT = 3;
  localparam int LIM_HW_IN = 4;
  localparam int LIM_HW_OUT = 5;
  localparam int LIM_HE_IN = 6;
  localparam int LIM_HE_OUT = 7;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               wired;
    logic               wless;
  } sample_t;

  // Zone limits in whole degrees, one row per source: wired, wireless, battery.
  int zone_limits [3][8] = '{'{0, 2, 5, 7, 40, 38, 45, 43},
                             '{0, 2, 5, 7, 43, 41, 45, 43},
                             '{0, 2, 5, 7, 43, 41, 50, 48}};
  int boundary_deg [11] = '{0, 2, 5, 7, 38, 40, 41, 43, 45, 48, 50};

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] temp_q8 = '0;
  logic wired_present = 1'b0;
  logic wireless_present = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] zone;
  logic [1:0] source;
  logic charging_enabled;
  logic [3:0] current_code;
  logic current_changed;
  logic [1:0] error_led_event;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  // Stimulus and expectation stores.
  sample_t sample_queue [$];
  result_t expected_results [$];
  sample_t next_sample;
  result_t want_result;
  logic sample_fire = 1'b0;
  logic cfg_fire = 1'b0;
  int fail_count = 0;
  int result_count = 0;

  // Predictor state and register copies.
  logic [2:0] held_zone = ZONE_NORMAL;
  logic [3:0] held_current = NO_CURRENT;
  logic [3:0] warn_setting = WARN_CODE_RESET;
  logic [3:0] normal_setting = NORMAL_CODE_RESET;

  // Sender and receiver pacing.
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int cycles_since_hold = 0;
  int stall_style = 0;
  int style_left = 0;

  // Stimulus generator state.
  int walk_temp = 20 * DEG;
  int walk_dir = 1;
  logic [1:0] attach_flags = 2'b10;

  thermal_charge_current_fsm #(
    .TEMP_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .temp_q8(temp_q8),
    .wired_present(wired_present),
    .wireless_present(wireless_present),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .zone(zone),
    .source(source),
    .charging_enabled(charging_enabled),
    .current_code(current_code),
    .current_changed(current_changed),
    .error_led_event(error_led_event),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case results stop coming.
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int limit_q8(logic [1:0] src, int col);
    return zone_limits[src][col] * DEG;
  endfunction

  function automatic logic zone_faulted(logic [2:0] z);
    return (z == ZONE_LOW_ERR) || (z == ZONE_HIGH_ERR);
  endfunction

  // Advance the zone machine by one sample and build the result it causes.
  function automatic result_t predict_zone_step(sample_t s);
    int t;
    logic [1:0] src;
    logic [2:0] nz;
    logic [3:0] prev_cur;
    logic attached;
    result_t r;
    t = int'($signed(s.temp));
    src = s.wired ? SRC_WIRED : (s.wless ? SRC_WIRELESS : SRC_BATT);
    attached = (src != SRC_BATT);
    prev_cur = held_current;
    nz = held_zone;
    case (held_zone)
      ZONE_LOW_ERR: begin
        if (t > limit_q8(src, LIM_LE_OUT)) nz = ZONE_LOW_WARN;
      end
      ZONE_LOW_WARN: begin
        if (t < limit_q8(src, LIM_LE_IN)) nz = ZONE_LOW_ERR;
        else if (t > limit_q8(src, LIM_LW_OUT)) nz = ZONE_NORMAL;
      end
      ZONE_HIGH_WARN: begin
        if (t < limit_q8(src, LIM_HW_OUT)) nz = ZONE_NORMAL;
        else if (t > limit_q8(src, LIM_HE_IN)) nz = ZONE_HIGH_ERR;
      end
      ZONE_HIGH_ERR: begin
        if (t < limit_q8(src, LIM_HE_OUT)) nz = ZONE_HIGH_WARN;
      end
      ZONE_NORMAL: begin
        if (t > limit_q8(src, LIM_HW_IN)) nz = ZONE_HIGH_WARN;
        else if (t < limit_q8(src, LIM_LW_IN)) nz = ZONE_LOW_WARN;
      end
      default: nz = ZONE_NORMAL;
    endcase
    // The current code is only reloaded while a charger is attached.
    if (attached) begin
      if (zone_faulted(nz)) held_current = NO_CURRENT;
      else if (nz == ZONE_NORMAL) held_current = normal_setting;
      else held_current = warn_setting;
    end
    r.error_led_event = LED_NONE;
    if (nz != held_zone) begin
      if (zone_faulted(nz)) r.error_led_event = LED_ON;
      else if (zone_faulted(held_zone)) r.error_led_event = LED_OFF;
    end
    held_zone = nz;
    r.zone = nz;
    r.source = src;
    r.charging_enabled = attached && !zone_faulted(nz);
    r.current_code = held_current;
    r.current_changed = (prev_cur != held_current);
    return r;
  endfunction

  task automatic report_failure(string msg);
    if (fail_count < 100) $display("MISMATCH result %0d: %s", result_count, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
    if (got !== want) report_failure($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Monitor: checks results, then records accepted requests and register writes.
  always @(posedge clk) begin
    sample_fire <= !rst && in_valid && !in_stall;
    cfg_fire <= !rst && cfg_valid && cfg_ready;
    if (rst) begin
      held_zone = ZONE_NORMAL;
      held_current = NO_CURRENT;
      warn_setting = WARN_CODE_RESET;
      normal_setting = NORMAL_CODE_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_failure("result with no request pending");
        end else begin
          want_result = expected_results.pop_front();
          check_field("zone", 4'(zone), 4'(want_result.zone));
          check_field("source", 4'(source), 4'(want_result.source));
          check_field("charging_enabled", 4'(charging_enabled),
                      4'(want_result.charging_enabled));
          check_field("current_code", current_code, want_result.current_code);
          check_field("current_changed", 4'(current_changed),
                      4'(want_result.current_changed));
          check_field("error_led_event", 4'(error_led_event),
                      4'(want_result.error_led_event));
        end
        result_count++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WARN_CODE) warn_setting = cfg_data;
        else if (cfg_index == REG_NORMAL_CODE) normal_setting = cfg_data;
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_zone_step('{temp_q8, wired_present,
                                                       wireless_present}));
      end
    end
  end

  // Driver: offers requests in bursts; gaps are skipped during a long result hold.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !sample_fire) begin
      // Request still stalled; hold the payload.
    end else if (gap_left != 0 && hold_left == 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (sample_queue.size() != 0) begin
      next_sample = sample_queue.pop_front();
      in_valid <= 1'b1;
      temp_q8 <= next_sample.temp;
      wired_present <= next_sample.wired;
      wireless_present <= next_sample.wless;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall pattern in random styles, plus an occasional long hold-off
  // while plenty of requests are queued so the block backs up.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
      cycles_since_hold <= 0;
    end else if (!rst && cycles_since_hold > 1000 && sample_queue.size() > 40) begin
      hold_left <= 80;
      out_stall <= 1'b1;
      cycles_since_hold <= 0;
    end else begin
      cycles_since_hold <= cycles_since_hold + 1;
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        style_left <= $urandom_range(10, 80);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((cycles_since_hold % 5) < 2);
      endcase
    end
  end

  task automatic add_sample(int t, logic wired, logic wless);
    sample_t s;
    s.temp = t[15:0];
    s.wired = wired;
    s.wless = wless;
    sample_queue.push_back(s);
  endtask

  // Wait until every request has been taken and answered.
  task automatic wait_for_drain();
    @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [3:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_fire) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Strict compares at the limit of each transition, source priority, battery
  // hold of the current code, LED events and the temperature extremes.
  task automatic queue_directed();
    add_sample(40 * DEG, 1'b1, 1'b0);
    add_sample(40 * DEG + 1, 1'b1, 1'b0);
    add_sample(45 * DEG, 1'b1, 1'b0);
    add_sample(45 * DEG + 1, 1'b1, 1'b0);
    add_sample(43 * DEG, 1'b1, 1'b0);
    add_sample(43 * DEG - 1, 1'b1, 1'b0);
    add_sample(38 * DEG, 1'b1, 1'b0);
    add_sample(38 * DEG - 1, 1'b1, 1'b0);
    add_sample(5 * DEG, 1'b0, 1'b1);
    add_sample(5 * DEG - 1, 1'b0, 1'b1);
    add_sample(0, 1'b1, 1'b1);
    add_sample(-1, 1'b0, 1'b0);
    add_sample(2 * DEG, 1'b0, 1'b0);
    add_sample(2 * DEG + 1, 1'b1, 1'b0);
    add_sample(7 * DEG, 1'b1, 1'b0);
    add_sample(7 * DEG + 1, 1'b0, 1'b1);
    add_sample(32767, 1'b0, 1'b0);
    add_sample(32767, 1'b0, 1'b0);
    add_sample(32767, 1'b1, 1'b0);
    add_sample(-32768, 1'b0, 1'b1);
    add_sample(-32768, 1'b0, 1'b1);
    add_sample(-32768, 1'b1, 1'b1);
    add_sample(-32768, 1'b1, 1'b0);
    add_sample(32767, 1'b1, 1'b0);
    add_sample(32767, 1'b1, 1'b0);
  endtask

  // Mostly a drifting temperature sweep that walks through every zone, with
  // samples right at the limits and some fully random words mixed in.
  task automatic queue_random_samples(int count);
    int t;
    int pick;
    int step;
    int offset;
    logic [31:0] word;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) attach_flags = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        word = $urandom();
        t = int'($signed(word[15:0]));
      end else if (pick < 22) begin
        offset = $urandom_range(0, 2);
        t = boundary_deg[$urandom_range(0, 10)] * DEG + offset - 1;
      end else begin
        step = $urandom_range(0, 500);
        walk_temp = walk_temp + walk_dir * step;
        if (walk_temp > 58 * DEG) walk_dir = -1;
        else if (walk_temp < -6 * DEG) walk_dir = 1;
        else if ($urandom_range(0, 49) == 0) walk_dir = -walk_dir;
        t = walk_temp;
      end
      add_sample(t, attach_flags[1], attach_flags[0]);
    end
  endtask

  // Main sequence: reset, directed samples, then random phases with
  // register writes between them while the block is idle.
  initial begin
    logic [3:0] warn_val;
    logic [3:0] normal_val;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    queue_directed();
    wait_for_drain();
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin warn_val = '0; normal_val = CODE_MAX; end
        1: begin warn_val = CODE_MAX; normal_val = '0; end
        2: begin warn_val = '0; normal_val = '0; end
        3: begin warn_val = CODE_MAX; normal_val = CODE_MAX; end
        default: begin
          warn_val = 4'($urandom_range(0, CODE_MAX));
          normal_val = 4'($urandom_range(0, CODE_MAX));
        end
      endcase
      if (phase % 2 == 0) begin
        write_register(REG_WARN_CODE, warn_val);
        write_register(REG_NORMAL_CODE, normal_val);
      end else begin
        write_register(REG_NORMAL_CODE, normal_val);
        write_register(REG_WARN_CODE, warn_val);
      end
      // Writes to unused indexes must leave both codes alone.
      write_register(CFG_IDX_W'($urandom_range(REG_NORMAL_CODE + 1, (1 << CFG_IDX_W) - 1)),
                     4'($urandom_range(0, CODE_MAX)));
      queue_random_samples(PHASE_SAMPLES);
      wait_for_drain();
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
